[hw/rtl/tilt_complementary_filter_defines.svh]
`ifndef TILT_COMPLEMENTARY_FILTER_DEFINES_SVH
`define TILT_COMPLEMENTARY_FILTER_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define TCF_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tcf: same-cycle check failed");

// Next-cycle implication, held off while reset is asserted.
`define TCF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tcf: next-cycle check failed");

`endif

[hw/rtl/tcf_pkg.sv]
`default_nettype none

package tcf_pkg;

    // Main sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RATE_MUL,
        ST_RATE,
        ST_DELTA_MUL,
        ST_DELTA_ABS,
        ST_RECIP_MUL,
        ST_DELTA,
        ST_BLEND_MUL,
        ST_BLEND_ACC,
        ST_ANGLE_WAIT,
        ST_ANGLE_MUL,
        ST_FINISH
    } tcf_state_t;

    // CORDIC sequencer states
    typedef enum logic [1:0] {
        CS_IDLE,
        CS_RUN,
        CS_ROUND
    } tcf_cordic_state_t;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLEND_WEIGHT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_GYRO_FS      = 1'b1;

    localparam logic [16:0] BLEND_WEIGHT_RESET = 17'd64225;
    localparam logic [10:0] GYRO_FS_RESET      = 11'd250;
    localparam logic [16:0] WEIGHT_ONE         = 17'd65536;

    // floor(m / 1000) == (m * RECIP_1000) >> RECIP_SHIFT for any m below 2^30
    localparam logic signed [31:0] RECIP_1000  = 32'sd1099511628;
    localparam int                 RECIP_SHIFT = 40;
    localparam logic [29:0]        DELTA_BIAS  = 30'd500;

    // atan(2^-i) in degrees, 20 fractional bits
    localparam int ATAN_LEN   = 24;
    localparam int ATAN_IDX_W = 5;
    localparam int ATAN_FRAC  = 20;
    localparam int ATAN_W     = 27;

    function automatic logic signed [ATAN_W-1:0] tcf_atan(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [ATAN_W-1:0] r;
        case (idx)
            5'd0:    r = 27'sd47185920;
            5'd1:    r = 27'sd27855475;
            5'd2:    r = 27'sd14718068;
            5'd3:    r = 27'sd7471121;
            5'd4:    r = 27'sd3750058;
            5'd5:    r = 27'sd1876857;
            5'd6:    r = 27'sd938658;
            5'd7:    r = 27'sd469357;
            5'd8:    r = 27'sd234682;
            5'd9:    r = 27'sd117342;
            5'd10:   r = 27'sd58671;
            5'd11:   r = 27'sd29335;
            5'd12:   r = 27'sd14668;
            5'd13:   r = 27'sd7334;
            5'd14:   r = 27'sd3667;
            5'd15:   r = 27'sd1833;
            5'd16:   r = 27'sd917;
            5'd17:   r = 27'sd458;
            5'd18:   r = 27'sd229;
            5'd19:   r = 27'sd115;
            5'd20:   r = 27'sd57;
            5'd21:   r = 27'sd29;
            5'd22:   r = 27'sd14;
            5'd23:   r = 27'sd7;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/tcf_cordic.sv]
`default_nettype none

module tcf_cordic
    import tcf_pkg::*;
#(
    parameter int ITERATIONS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic signed [15:0]        vec_x,
    input  wire logic signed [15:0]        vec_y,
    output logic                           done,
    output logic signed [FRAC_BITS+8:0]    angle
);

    localparam int CW = 25;
    localparam int AW = 30;
    localparam int PW = FRAC_BITS + 9;
    localparam int SH = ATAN_FRAC - FRAC_BITS;
    // no more steps than the arctangent table holds
    localparam logic [ATAN_IDX_W-1:0] LAST =
        ATAN_IDX_W'(((ITERATIONS > ATAN_LEN) ? ATAN_LEN : ITERATIONS) - 1);
    localparam logic signed [AW-1:0]  ACC_90 = AW'(90 * (1 << ATAN_FRAC));
    localparam logic signed [AW-1:0]  HALF_POS = AW'(1 << (SH - 1));
    localparam logic signed [AW-1:0]  HALF_NEG = AW'((1 << (SH - 1)) - 1);

    tcf_cordic_state_t state_reg, state_next;
    logic signed [CW-1:0]   x_reg, x_next;
    logic signed [CW-1:0]   y_reg, y_next;
    logic signed [AW-1:0]   acc_reg, acc_next;
    logic [ATAN_IDX_W-1:0]  iter_reg, iter_next;
    logic                   zero_reg, zero_next;
    logic                   done_reg, done_next;
    logic signed [PW-1:0]   angle_reg, angle_next;

    logic signed [CW-1:0]   x_in, y_in, x_shift, y_shift;
    logic signed [AW-1:0]   step_angle, round_sum, round_val;

    assign x_in       = CW'(vec_x) <<< 6;
    assign y_in       = CW'(vec_y) <<< 6;
    assign x_shift    = x_reg >>> iter_reg;
    assign y_shift    = y_reg >>> iter_reg;
    assign step_angle = AW'(tcf_atan(iter_reg));
    assign round_sum  = acc_reg + (acc_reg[AW-1] ? HALF_NEG : HALF_POS);
    assign round_val  = round_sum >>> SH;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        x_reg     <= x_next;
        y_reg     <= y_next;
        acc_reg   <= acc_next;
        iter_reg  <= iter_next;
        zero_reg  <= zero_next;
        angle_reg <= angle_next;
    end

    always_comb begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        iter_next  = iter_reg;
        zero_next  = zero_reg;
        done_next  = done_reg;
        angle_next = angle_reg;
        case (state_reg)
            CS_IDLE: begin
                if (start) begin
                    done_next  = 1'b0;
                    zero_next  = (vec_x == 16'sd0) && (vec_y == 16'sd0);
                    iter_next  = '0;
                    state_next = CS_RUN;
                    // turn a left-half-plane vector by 90 degrees first
                    if (x_in < 0) begin
                        if (y_in >= 0) begin
                            x_next   = y_in;
                            y_next   = -x_in;
                            acc_next = ACC_90;
                        end else begin
                            x_next   = -y_in;
                            y_next   = x_in;
                            acc_next = -ACC_90;
                        end
                    end else begin
                        x_next   = x_in;
                        y_next   = y_in;
                        acc_next = '0;
                    end
                end
            end
            CS_RUN: begin
                if (!y_reg[CW-1]) begin
                    x_next   = x_reg + y_shift;
                    y_next   = y_reg - x_shift;
                    acc_next = acc_reg + step_angle;
                end else begin
                    x_next   = x_reg - y_shift;
                    y_next   = y_reg + x_shift;
                    acc_next = acc_reg - step_angle;
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == LAST) begin
                    state_next = CS_ROUND;
                end
            end
            CS_ROUND: begin
                angle_next = zero_reg ? '0 : round_val[PW-1:0];
                done_next  = 1'b1;
                state_next = CS_IDLE;
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

`default_nettype wire

[hw/rtl/tilt_complementary_filter.sv]
// Pitch-only complementary filter. Each input item is one inertial sample
// (accelerometer X and Z, gyro Y, milliseconds since the previous sample) and
// yields one result item: the new filtered pitch and the scaled gyro rate,
// both in 1/2^ANGLE_FRAC_BITS degree (per second for the rate). The result
// waits for the iterative vectoring CORDIC that finds atan2(Z, X), while the
// rate scaling, integration and blend run beside it through one shared 32 x 32
// multiplier. A new item is taken only once the last one has put its result
// into the output register.
// s_tready is high only between items; a result waiting in the output register
// does not block the next sample, but the following result waits until that
// one is taken. Configuration writes are meant for idle periods: blend_weight
// (index 0, gyro weight in 1/65536, values above 65536 act as 65536) and
// gyro_full_scale_dps (index 1).
`default_nettype none

`include "tilt_complementary_filter_defines.svh"

module tilt_complementary_filter
    import tcf_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int ANGLE_FRAC_BITS   = 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [16:0]            cfg_wdata,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // accel_x[15:0], accel_z[31:16], gyro_y[47:32], elapsed_ms[57:48], zero pad
    input  wire logic [63:0]            s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // pitch_angle[16:0], pitch_rate[36:17], zero pad
    output logic [39:0]                 m_tdata
);

    localparam int PW = ANGLE_FRAC_BITS + 9;
    localparam logic signed [47:0] RATE_HI  = 48'sd524287;
    localparam logic signed [47:0] RATE_LO  = -48'sd524288;
    localparam logic signed [40:0] PITCH_HI = 41'(180 * (1 << ANGLE_FRAC_BITS));
    localparam logic signed [40:0] PITCH_LO = -PITCH_HI;

    tcf_state_t state_reg, state_next;
    logic [16:0]          blend_weight_reg;
    logic [10:0]          gyro_fs_reg;
    logic signed [31:0]   mul_a_reg, mul_a_next;
    logic signed [31:0]   mul_b_reg, mul_b_next;
    logic signed [63:0]   prod_reg, prod_next;
    logic [9:0]           ms_reg, ms_next;
    logic signed [19:0]   rate_reg, rate_next;
    logic                 neg_reg, neg_next;
    logic signed [39:0]   accum_reg, accum_next;
    logic signed [PW-1:0] pitch_reg, pitch_next;
    logic                 m_valid_reg, m_valid_next;
    logic [16:0]          m_pitch_reg, m_pitch_next;
    logic [19:0]          m_rate_reg, m_rate_next;

    logic                 accept;
    logic                 cordic_done;
    logic signed [PW-1:0] cordic_angle;
    logic [16:0]          w_eff, w_comp;

    logic signed [47:0]   rate_scaled, rate_round, rate_sat;
    logic signed [19:0]   rate_val;
    logic signed [30:0]   dprod, dmag;
    logic [29:0]          dmag_bias;
    logic [19:0]          quot;
    logic signed [20:0]   delta_val;
    logic signed [21:0]   blend_sum;
    logic signed [40:0]   mix_sum, mix_round, mix_sat;
    logic signed [PW-1:0] pitch_new;
    logic signed [31:0]   pitch_new_wide, pitch_reg_wide;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    tcf_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS),
        .FRAC_BITS  (ANGLE_FRAC_BITS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .vec_x   (s_tdata[15:0]),
        .vec_y   (s_tdata[31:16]),
        .done    (cordic_done),
        .angle   (cordic_angle)
    );

    assign w_eff  = (blend_weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : blend_weight_reg;
    assign w_comp = WEIGHT_ONE - w_eff;

    // shared multiplier, product registered
    assign prod_next = mul_a_reg * mul_b_reg;

    // rate = round(gyro * fs * 2^F / 32768), then saturate to 20 bits
    assign rate_scaled = 48'($signed(prod_reg[27:0])) <<< ANGLE_FRAC_BITS;
    assign rate_round  = (rate_scaled + (rate_scaled[47] ? 48'sd16383 : 48'sd16384)) >>> 15;
    assign rate_sat    = (rate_round > RATE_HI) ? RATE_HI :
                         ((rate_round < RATE_LO) ? RATE_LO : rate_round);
    assign rate_val    = rate_sat[19:0];

    // delta = round(rate * ms / 1000) by reciprocal on the magnitude
    assign dprod     = prod_reg[30:0];
    assign dmag      = dprod[30] ? -dprod : dprod;
    assign dmag_bias = dmag[29:0] + DELTA_BIAS;
    assign quot      = prod_reg[RECIP_SHIFT+19:RECIP_SHIFT];
    assign delta_val = neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    assign blend_sum = 22'(pitch_reg) + 22'(delta_val);

    // blend, round by 65536 and saturate at plus or minus 180 degrees
    assign mix_sum   = 41'(accum_reg) + 41'($signed(prod_reg[39:0]));
    assign mix_round = (mix_sum + (mix_sum[40] ? 41'sd32767 : 41'sd32768)) >>> 16;
    assign mix_sat   = (mix_round > PITCH_HI) ? PITCH_HI :
                       ((mix_round < PITCH_LO) ? PITCH_LO : mix_round);
    assign pitch_new = mix_sat[PW-1:0];

    assign pitch_new_wide = 32'(pitch_new);
    assign pitch_reg_wide = 32'(pitch_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            blend_weight_reg <= BLEND_WEIGHT_RESET;
            gyro_fs_reg      <= GYRO_FS_RESET;
            pitch_reg        <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pitch_reg   <= pitch_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_BLEND_WEIGHT: blend_weight_reg <= cfg_wdata;
                    REG_GYRO_FS:      gyro_fs_reg      <= cfg_wdata[10:0];
                    default:          ;
                endcase
            end
        end
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        prod_reg    <= prod_next;
        ms_reg      <= ms_next;
        rate_reg    <= rate_next;
        neg_reg     <= neg_next;
        accum_reg   <= accum_next;
        m_pitch_reg <= m_pitch_next;
        m_rate_reg  <= m_rate_next;
    end

    always_comb begin
        state_next   = state_reg;
        mul_a_next   = mul_a_reg;
        mul_b_next   = mul_b_reg;
        ms_next      = ms_reg;
        rate_next    = rate_reg;
        neg_next     = neg_reg;
        accum_next   = accum_reg;
        pitch_next   = pitch_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_pitch_next = m_pitch_reg;
        m_rate_next  = m_rate_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    mul_a_next = 32'($signed(s_tdata[47:32]));
                    mul_b_next = 32'(gyro_fs_reg);
                    ms_next    = s_tdata[57:48];
                    state_next = ST_RATE_MUL;
                end
            end
            ST_RATE_MUL: begin
                state_next = ST_RATE;
            end
            ST_RATE: begin
                rate_next  = rate_val;
                mul_a_next = 32'(rate_val);
                mul_b_next = 32'(ms_reg);
                state_next = ST_DELTA_MUL;
            end
            ST_DELTA_MUL: begin
                state_next = ST_DELTA_ABS;
            end
            ST_DELTA_ABS: begin
                neg_next   = dprod[30];
                mul_a_next = 32'(dmag_bias);
                mul_b_next = RECIP_1000;
                state_next = ST_RECIP_MUL;
            end
            ST_RECIP_MUL: begin
                state_next = ST_DELTA;
            end
            ST_DELTA: begin
                mul_a_next = 32'(w_eff);
                mul_b_next = 32'(blend_sum);
                state_next = ST_BLEND_MUL;
            end
            ST_BLEND_MUL: begin
                state_next = ST_BLEND_ACC;
            end
            ST_BLEND_ACC: begin
                accum_next = prod_reg[39:0];
                state_next = ST_ANGLE_WAIT;
            end
            ST_ANGLE_WAIT: begin
                // hold until the accelerometer angle is out of the CORDIC
                if (cordic_done) begin
                    mul_a_next = 32'(w_comp);
                    mul_b_next = 32'(cordic_angle);
                    state_next = ST_ANGLE_MUL;
                end
            end
            ST_ANGLE_MUL: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    pitch_next   = pitch_new;
                    m_pitch_next = pitch_new_wide[16:0];
                    m_rate_next  = rate_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_rate_reg, m_pitch_reg};

    `TCF_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, accept, !s_tready)
    `TCF_ASSERT_NOW(a_angle_ready, aclk, aresetn, state_reg == ST_ANGLE_MUL, cordic_done)
    `TCF_ASSERT_NOW(a_recip_fits, aclk, aresetn, state_reg == ST_DELTA, prod_reg[63:60] == 4'b0000)
    `TCF_ASSERT_NOW(a_result_from_finish, aclk, aresetn, $rose(m_valid_reg), $past(state_reg == ST_FINISH))
    `TCF_ASSERT_NOW(a_result_matches_state, aclk, aresetn, m_valid_reg, m_pitch_reg == pitch_reg_wide[16:0])

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;
    import tcf_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int CORDIC_STEPS = 16;
    localparam int SETTLE       = 40;
    localparam int PHASE_ITEMS  = 150;

    typedef struct packed {
        logic [9:0]  ms;
        logic [15:0] gy;
        logic [15:0] az;
        logic [15:0] ax;
    } imu_sample_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_BLEND_WEIGHT;
    logic [16:0]            cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [63:0]            s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [39:0]            m_tdata;

    tilt_complementary_filter i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Filter state and register copies
    longint      pitch_est  = 0;
    logic [16:0] gain_q16   = 17'd64225;
    logic [10:0] full_scale = 11'd250;

    imu_sample_t pending_samples[$];
    logic [39:0] expected_results[$];

    int   idle_odds       = 7;
    int   src_gap         = 0;
    int   sink_wait       = 0;
    logic long_stall_done = 1'b0;
    int   results_seen    = 0;
    int   mismatches      = 0;
    int   cycles          = 0;
    logic [39:0] want;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint round_half_away(longint v, longint d);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + d / 2) / d;
        return (v < 0) ? -m : m;
    endfunction

    // atan(2^-i) in degrees, 20 fractional bits
    function automatic longint atan_q20(int i);
        case (i)
            0:  return 47185920;
            1:  return 27855475;
            2:  return 14718068;
            3:  return 7471121;
            4:  return 3750058;
            5:  return 1876857;
            6:  return 938658;
            7:  return 469357;
            8:  return 234682;
            9:  return 117342;
            10: return 58671;
            11: return 29335;
            12: return 14668;
            13: return 7334;
            14: return 3667;
            15: return 1833;
            16: return 917;
            17: return 458;
            18: return 229;
            19: return 115;
            20: return 57;
            21: return 29;
            22: return 14;
            23: return 7;
            default: return 0;
        endcase
    endfunction

    // atan2(z, x) in 1/256 degree, vectoring rotation
    function automatic longint accel_pitch(longint zv, longint xv);
        longint x, y, a, t, xs, ys;
        x = xv * 64;
        y = zv * 64;
        a = 0;
        if (xv == 0 && zv == 0) return 0;
        // turn into the right half plane first
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t;
                a = longint'(90) << 20;
            end else begin
                t = x; x = -y; y = t;
                a = -(longint'(90) << 20);
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; a = a + atan_q20(i);
            end else begin
                x = x - ys; y = y + xs; a = a - atan_q20(i);
            end
        end
        return round_half_away(a, longint'(4096));
    endfunction

    function automatic logic [39:0] filter_step(logic [63:0] d);
        longint ax, az, gy, ms, w, acc, rate, delta, mixed;
        logic [39:0] r;
        ax = longint'($signed(d[15:0]));
        az = longint'($signed(d[31:16]));
        gy = longint'($signed(d[47:32]));
        ms = longint'(d[57:48]);
        w  = (gain_q16 > 17'd65536) ? 65536 : longint'(gain_q16);
        acc  = accel_pitch(az, ax);
        rate = round_half_away(gy * longint'(full_scale) * 256, 32768);
        if (rate > 524287) rate = 524287;
        if (rate < -524288) rate = -524288;
        delta = round_half_away(rate * ms, 1000);
        mixed = round_half_away(w * (pitch_est + delta) + (65536 - w) * acc, 65536);
        if (mixed > 46080) mixed = 46080;
        if (mixed < -46080) mixed = -46080;
        pitch_est = mixed;
        r = '0;
        r[16:0]  = pitch_est[16:0];
        r[36:17] = rate[19:0];
        return r;
    endfunction

    function automatic logic [15:0] pick_axis();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 32)) - 16'd16;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic imu_sample_t random_sample();
        imu_sample_t s;
        s.ax = pick_axis();
        s.az = pick_axis();
        s.gy = pick_axis();
        case ($urandom_range(0, 7))
            0: s.ms = 10'd0;
            1: s.ms = 10'd1023;
            2, 3: s.ms = 10'($urandom_range(0, 1023));
            default: s.ms = 10'($urandom_range(1, 20));
        endcase
        return s;
    endfunction

    task automatic queue_sample(int ax, int az, int gy, int ms);
        imu_sample_t s;
        s.ax = 16'(ax);
        s.az = 16'(az);
        s.gy = 16'(gy);
        s.ms = 10'(ms);
        pending_samples.push_back(s);
    endtask

    task automatic report_mismatch(string what, longint got, longint exp_val);
        mismatches++;
        $display("tb: mismatch on %s: got %0d, expected %0d", what, got, exp_val);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [16:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_BLEND_WEIGHT)
            gain_q16 = val;
        else
            full_scale = val[10:0];
        @(negedge aclk);
    endtask

    // hold until every item is in and every result is out, then let the block settle
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_samples.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // Sender: offer items from the pending queue, predict each one on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            src_gap   <= 0;
            pitch_est = 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(filter_step(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (src_gap != 0) begin
                    s_tvalid <= 1'b0;
                    src_gap  <= src_gap - 1;
                end else if (pending_samples.size() != 0) begin
                    s_tdata  <= {6'b0, pending_samples.pop_front()};
                    s_tvalid <= 1'b1;
                    if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0)
                        src_gap <= $urandom_range(1, 13);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready: random bursts of back-pressure, one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_wait <= 0;
        end else if (sink_wait != 0) begin
            m_tready  <= 1'b0;
            sink_wait <= sink_wait - 1;
        end else if (!long_stall_done && results_seen >= 200) begin
            long_stall_done <= 1'b1;
            sink_wait       <= 300;
            m_tready        <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
            sink_wait <= $urandom_range(0, 12);
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, pitch", longint'($signed(m_tdata[16:0])), 0);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[16:0] !== want[16:0])
                    report_mismatch("pitch_angle", longint'($signed(m_tdata[16:0])),
                                    longint'($signed(want[16:0])));
                if (m_tdata[36:17] !== want[36:17])
                    report_mismatch("pitch_rate", longint'($signed(m_tdata[36:17])),
                                    longint'($signed(want[36:17])));
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        logic [16:0] weights[8];
        logic [10:0] scales[8];

        weights = '{17'd65536, 17'd0, 17'd131071, 17'd64225, 17'd32768, 17'd65535,
                    17'($urandom_range(0, 131071)), 17'($urandom_range(0, 65536))};
        scales  = '{11'd2000, 11'd250, 11'd2047, 11'd0, 11'd1000, 11'd1,
                    11'($urandom_range(0, 2047)), 11'($urandom_range(250, 2000))};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed samples at the reset settings
        queue_sample(0, 0, 0, 0);               // both axes zero
        queue_sample(-16384, 0, 0, 10);         // negative X, zero Z: half turn
        queue_sample(-16384, 100, 0, 10);
        queue_sample(-16384, -100, 0, 10);
        queue_sample(0, 16384, 0, 10);
        queue_sample(0, -16384, 0, 10);
        queue_sample(16384, 0, 0, 10);
        queue_sample(32767, 32767, 32767, 1023);
        queue_sample(-32768, -32768, -32768, 1023);
        queue_sample(-32768, 32767, 32767, 1023);
        queue_sample(32767, -32768, -32768, 0);
        queue_sample(1, 0, 1, 1);
        queue_sample(-1, 0, -1, 1);
        queue_sample(-1, -1, 0, 1);
        queue_sample(0, 1, 0, 1);
        // drive the kept pitch into both rails
        repeat (4) queue_sample(0, 0, 32767, 1023);
        repeat (4) queue_sample(0, 0, -32768, 1023);
        wait_drained();

        for (int p = 0; p < 9; p++) begin
            idle_odds = (p == 2) ? 0 : 7;
            if (p == 8) begin
                idle_odds = 0;
                write_reg(REG_BLEND_WEIGHT, 17'd64225);
                write_reg(REG_GYRO_FS, 17'($urandom_range(0, 2047)));
            end else begin
                write_reg(REG_BLEND_WEIGHT, weights[p]);
                write_reg(REG_GYRO_FS, {6'b0, scales[p]});
            end
            repeat (PHASE_ITEMS) pending_samples.push_back(random_sample());
            wait_drained();
        end

        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
